### hdl/replay_key_table_with_expiry_top_defines.svh
// replay_key_table_with_expiry_top_defines.svh: assertion macros for the replay key table
// no dependencies
`ifndef REPLAY_KEY_TABLE_WITH_EXPIRY_TOP_DEFINES_SVH
`define REPLAY_KEY_TABLE_WITH_EXPIRY_TOP_DEFINES_SVH
// implication checked on every clock unless reset is high
`define RKT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication checked on every clock unless reset is high
`define RKT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### hdl/rkt_pkg.sv
// rkt_pkg.sv: shared types and constants of the replay key table
// no dependencies
`timescale 1ns / 1ps
package rkt_pkg;
   localparam int ENTRIES   = 16;
   localparam int KEY_BITS  = 256;
   localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int TIME_W    = 64;
   localparam int REQ_DATA_W = 392;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [1:0] {
      OP_RESERVE = 2'd0,
      OP_CONSUME = 2'd1,
      OP_RELEASE = 2'd2,
      OP_GET     = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EXISTS    = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_ERROR     = 3'd4
   } status_type;

   localparam logic [1:0] MARK_RESERVED = 2'd0;
   localparam logic [1:0] MARK_CONSUMED = 2'd1;
   localparam logic [1:0] MARK_RELEASED = 2'd2;

   // classified request from front to back
   typedef struct packed {
      op_type                     op;
      logic                       early_err;
      logic [KEY_BITS-1:0]        key;
      logic signed [TIME_W-1:0]   expiry;
      logic signed [TIME_W-1:0]   now;
   } job_type;

   typedef struct packed {
      status_type  status;
      logic [1:0]  mark;
      logic        mark_valid;
   } result_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_ACT,
      BK_DONE
   } back_state_type;
endpackage

### hdl/rkt_front.sv
// rkt_front.sv: accepts requests, checks reserve expiry and queues jobs
// depends on rkt_pkg
`timescale 1ns / 1ps
module rkt_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [1:0]                     in_op,
   input  logic [rkt_pkg::KEY_BITS-1:0]   in_key,
   input  logic signed [63:0]             in_expiry,
   input  logic signed [63:0]             in_now,
   output logic                           job_valid,
   input  logic                           job_ready,
   output rkt_pkg::job_type               job
);
   // two-entry queue
   rkt_pkg::job_type q_ff [2];
   rkt_pkg::job_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   rkt_pkg::job_type newjob;
   logic push, pop;

   always_comb begin
      newjob.op        = rkt_pkg::op_type'(in_op);
      newjob.early_err = (in_op == rkt_pkg::OP_RESERVE) && (in_expiry <= in_now);
      newjob.key       = in_key;
      newjob.expiry    = in_expiry;
      newjob.now       = in_now;
   end

   assign in_ready  = (cnt_ff != 2'd2);
   assign push      = in_valid && in_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop       = job_valid && job_ready;
   assign job       = q_ff[0];

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         if (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)) q_in[0] = newjob;
         else q_in[1] = newjob;
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) cnt_ff <= 2'd0;
      else cnt_ff <= cnt_in;
   end
endmodule

### hdl/rkt_back.sv
// rkt_back.sv: purges, searches and updates the slot table one slot per cycle
// depends on rkt_pkg
`timescale 1ns / 1ps
module rkt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  rkt_pkg::job_type     job,
   output logic                 res_valid,
   input  logic                 res_ready,
   output rkt_pkg::result_type  res
);
   localparam int E = rkt_pkg::ENTRIES;
   localparam int IW = rkt_pkg::IDX_W;

   logic [E-1:0] valid_ff, valid_in;
   logic [rkt_pkg::KEY_BITS-1:0] key_ff [E];
   logic signed [63:0] exp_ff [E];
   logic [1:0] mark_ff [E];

   rkt_pkg::back_state_type st_ff, st_in;
   rkt_pkg::job_type j_ff, j_in;
   logic [rkt_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic hit_ff, hit_in, free_ff, free_in;
   logic [IW-1:0] hidx_ff, hidx_in, fidx_ff, fidx_in;
   rkt_pkg::result_type res_ff, res_in;
   logic rv_ff, rv_in;

   logic [IW-1:0] cur;
   logic alive, match;
   logic do_write, do_mark, take;
   logic [1:0] new_mark;

   assign cur   = idx_ff[IW-1:0];
   assign alive = valid_ff[cur] && !(exp_ff[cur] <= j_ff.now);
   assign match = alive && (key_ff[cur] == j_ff.key);
   assign take  = job_valid && job_ready;
   // a waiting result keeps the next job out so the result register holds
   assign job_ready = (st_ff == rkt_pkg::BK_IDLE) && (!rv_ff || res_ready);
   assign res_valid = rv_ff;
   assign res = res_ff;

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         rkt_pkg::BK_IDLE: begin
            if (take) st_in = job.early_err ? rkt_pkg::BK_DONE : rkt_pkg::BK_SCAN;
         end
         rkt_pkg::BK_SCAN: begin
            if (idx_ff == rkt_pkg::CNT_W'(E - 1)) st_in = rkt_pkg::BK_ACT;
         end
         rkt_pkg::BK_ACT:  st_in = rkt_pkg::BK_DONE;
         rkt_pkg::BK_DONE: begin
            if (!rv_ff || res_ready) st_in = rkt_pkg::BK_IDLE;
         end
         default: st_in = rkt_pkg::BK_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      j_in = j_ff; idx_in = idx_ff; hit_in = hit_ff; free_in = free_ff;
      hidx_in = hidx_ff; fidx_in = fidx_ff; valid_in = valid_ff;
      res_in = res_ff; rv_in = rv_ff && !res_ready;
      do_write = 1'b0; do_mark = 1'b0; new_mark = rkt_pkg::MARK_RESERVED;
      case (st_ff)
         rkt_pkg::BK_IDLE: begin
            if (take) begin
               j_in = job; idx_in = '0; hit_in = 1'b0; free_in = 1'b0;
               res_in.status = rkt_pkg::ST_ERROR;
               res_in.mark = 2'd0;
               res_in.mark_valid = 1'b0;
            end
         end
         rkt_pkg::BK_SCAN: begin
            // purge as we go
            valid_in[cur] = alive;
            if (match && !hit_ff) begin
               hit_in = 1'b1; hidx_in = cur;
            end
            if (!alive && !free_ff) begin
               free_in = 1'b1; fidx_in = cur;
            end
            idx_in = idx_ff + 1'b1;
         end
         rkt_pkg::BK_ACT: begin
            res_in.mark = 2'd0;
            res_in.mark_valid = 1'b0;
            if (j_ff.op == rkt_pkg::OP_RESERVE) begin
               if (hit_ff) res_in.status = rkt_pkg::ST_EXISTS;
               else if (free_ff) begin
                  res_in.status = rkt_pkg::ST_OK;
                  do_write = 1'b1;
                  valid_in[fidx_ff] = 1'b1;
               end else res_in.status = rkt_pkg::ST_FULL;
            end else if (!hit_ff) begin
               res_in.status = rkt_pkg::ST_NOT_FOUND;
            end else begin
               res_in.status = rkt_pkg::ST_OK;
               case (j_ff.op)
                  rkt_pkg::OP_CONSUME: begin
                     do_mark = 1'b1; new_mark = rkt_pkg::MARK_CONSUMED;
                  end
                  rkt_pkg::OP_RELEASE: begin
                     do_mark = 1'b1; new_mark = rkt_pkg::MARK_RELEASED;
                  end
                  default: begin
                     res_in.mark = mark_ff[hidx_ff];
                     res_in.mark_valid = 1'b1;
                  end
               endcase
            end
         end
         rkt_pkg::BK_DONE: begin
            if (!rv_ff || res_ready) rv_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      j_ff <= j_in; idx_ff <= idx_in; hidx_ff <= hidx_in; fidx_ff <= fidx_in;
      hit_ff <= hit_in; free_ff <= free_in; res_ff <= res_in;
      if (do_write) begin
         key_ff[fidx_ff]  <= j_ff.key;
         exp_ff[fidx_ff]  <= j_ff.expiry;
         mark_ff[fidx_ff] <= rkt_pkg::MARK_RESERVED;
      end
      if (do_mark) mark_ff[hidx_ff] <= new_mark;
      if (reset) begin
         st_ff <= rkt_pkg::BK_IDLE; valid_ff <= '0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; valid_ff <= valid_in; rv_ff <= rv_in;
      end
   end
endmodule

### hdl/replay_key_table_with_expiry_top.sv
// replay_key_table_with_expiry_top.sv: replay key table with expiry, top level
// depends on rkt_pkg, rkt_front, rkt_back
`timescale 1ns / 1ps
// channel   | dir | ports               | contents
// request   | in  | req_t{valid,ready,data} | type, key words 0..3, expiry, now
// response  | out | rsp_t{valid,ready,data} | status, mark_out, mark_valid
//
// a request holds the back end from the state that takes it, through the scan that purges and
// compares one slot per cycle and the act step, to the state that posts the result
// a reserve with expiry not after now skips the scan and the act step
// the front queue holds two requests, so requests are taken while one is at work
// reset is synchronous and clears the valid marks, the queue and the response
// a stalled response holds the back end; the queue keeps accepting until full
module replay_key_table_with_expiry_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // req_type[1:0], key_word0..3[257:2], expiry_time[321:258],
   // now_time[385:322], zero fill [391:386]
   input  logic [rkt_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[2:0], mark_out[4:3], mark_valid[5], zero fill [7:6]
   output logic [rkt_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   logic job_valid, job_ready;
   rkt_pkg::job_type job;
   rkt_pkg::result_type res;

   rkt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tdata[1:0]),
      .in_key    (req_tdata[2 +: rkt_pkg::KEY_BITS]),
      .in_expiry (req_tdata[321:258]),
      .in_now    (req_tdata[385:322]),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job)
   );

   rkt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job),
      .res_valid (rsp_tvalid),
      .res_ready (rsp_tready),
      .res       (res)
   );

   // pack the response
   assign rsp_tdata = {2'b00, res.mark_valid, res.mark, res.status};
endmodule

### hdl/rkt_checker.sv
// rkt_checker.sv: port-level assertions, bound to the top level
// depends on replay_key_table_with_expiry_top_defines.svh and rkt_pkg
`timescale 1ns / 1ps
`include "replay_key_table_with_expiry_top_defines.svh"
module rkt_checker (
   input logic          clock,
   input logic          reset,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [7:0]    rsp_tdata
);
   logic       rsp_stall;
   logic [2:0] rsp_status;
   logic [1:0] rsp_mark;
   logic       rsp_mvalid;
   logic [1:0] rsp_fill;

   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_status = rsp_tdata[2:0];
   assign rsp_mark   = rsp_tdata[4:3];
   assign rsp_mvalid = rsp_tdata[5];
   assign rsp_fill   = rsp_tdata[7:6];

   // a stalled response transaction holds
   `RKT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   // status code stays within the defined set
   `RKT_ASSERT_IMPL(a_status, clock, reset, rsp_tvalid, rsp_status <= rkt_pkg::ST_ERROR)
   // a mark is reported only with ok status
   `RKT_ASSERT_IMPL(a_mark_ok, clock, reset, rsp_tvalid && rsp_mvalid, rsp_status == rkt_pkg::ST_OK)
   // without mark_valid, the mark value and the fill bits are zero
   `RKT_ASSERT_IMPL(a_mark_zero, clock, reset, rsp_tvalid && !rsp_mvalid, rsp_mark == 2'd0 && rsp_fill == 2'd0)
endmodule

bind replay_key_table_with_expiry_top rkt_checker u_rkt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### bench/tb_replay_checker.sv
// tb_replay_checker.sv: watches request and response transactions of the replay key table,
// predicts each response from a private table copy and compares it
// depends on rkt_pkg
`timescale 1ns / 1ps
module tb_replay_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [rkt_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [7:0]    rsp_tdata,
   output int            fail_count,
   output int            pending_count
);
   // lowest bit first as on rsp_tdata: status, mark, mark_valid
   typedef struct packed {
      logic       mark_valid;
      logic [1:0] mark;
      logic [2:0] status;
   } answer_type;

   logic                            tbl_valid [rkt_pkg::ENTRIES];
   logic [rkt_pkg::KEY_BITS-1:0]    tbl_key   [rkt_pkg::ENTRIES];
   logic signed [63:0]              tbl_exp   [rkt_pkg::ENTRIES];
   logic [1:0]                      tbl_mark  [rkt_pkg::ENTRIES];
   answer_type                      answers_due[$];

   function automatic answer_type serve_request(logic [rkt_pkg::REQ_DATA_W-1:0] d);
      logic [1:0]                   op;
      logic [rkt_pkg::KEY_BITS-1:0] key;
      logic signed [63:0]           expiry, now;
      answer_type                   a;
      int                           hit;
      op = d[1:0];
      key = d[257:2];
      expiry = d[321:258];
      now = d[385:322];
      a = '0;
      a.status = rkt_pkg::ST_OK;
      if (op == rkt_pkg::OP_RESERVE && expiry <= now) begin
         a.status = rkt_pkg::ST_ERROR;
         return a;
      end
      // expire everything at or before now
      for (int i = 0; i < rkt_pkg::ENTRIES; i++)
         if (tbl_valid[i] && tbl_exp[i] <= now) tbl_valid[i] = 1'b0;
      hit = -1;
      for (int i = 0; i < rkt_pkg::ENTRIES; i++)
         if (hit < 0 && tbl_valid[i] && tbl_key[i] == key) hit = i;
      if (op == rkt_pkg::OP_RESERVE) begin
         if (hit >= 0) begin
            a.status = rkt_pkg::ST_EXISTS;
         end else begin
            a.status = rkt_pkg::ST_FULL;
            for (int i = 0; i < rkt_pkg::ENTRIES; i++)
               if (a.status == rkt_pkg::ST_FULL && !tbl_valid[i]) begin
                  tbl_valid[i] = 1'b1;
                  tbl_key[i] = key;
                  tbl_exp[i] = expiry;
                  tbl_mark[i] = rkt_pkg::MARK_RESERVED;
                  a.status = rkt_pkg::ST_OK;
               end
         end
      end else if (hit < 0) begin
         a.status = rkt_pkg::ST_NOT_FOUND;
      end else if (op == rkt_pkg::OP_CONSUME) begin
         tbl_mark[hit] = rkt_pkg::MARK_CONSUMED;
      end else if (op == rkt_pkg::OP_RELEASE) begin
         tbl_mark[hit] = rkt_pkg::MARK_RELEASED;
      end else begin
         a.mark = tbl_mark[hit];
         a.mark_valid = 1'b1;
      end
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want, got;
      if (reset) begin
         for (int i = 0; i < rkt_pkg::ENTRIES; i++) tbl_valid[i] = 1'b0;
         answers_due.delete();
         fail_count = 0;
      end else begin
         if (req_tvalid && req_tready) answers_due.push_back(serve_request(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[5:0];
            if (answers_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response transaction %h", rsp_tdata);
            end else begin
               want = answers_due.pop_front();
               if (got !== want || rsp_tdata[7:6] !== 2'b00) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: status exp %0d got %0d, mark exp %0d got %0d, %s",
                        want.status, got.status, want.mark, got.mark,
                        $sformatf("mark_valid exp %0b got %0b", want.mark_valid,
                        got.mark_valid));
               end
            end
         end
      end
      pending_count = answers_due.size();
   end
endmodule

### bench/tb.sv
// tb.sv: stimulus and verdict for the replay key table
// depends on rkt_pkg, replay_key_table_with_expiry_top, tb_replay_checker
`timescale 1ns / 1ps
module tb;
   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [rkt_pkg::REQ_DATA_W-1:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [7:0]    rsp_tdata;
   int            fail_count, pending_count;
   int            cycle_count = 0;
   logic          quiet_phase = 1'b0;   // no idling near the end

   // small pool of keys so that hits, duplicates and full tables happen often
   logic [255:0]  key_pool [8];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   replay_key_table_with_expiry_top u_dut (.*);

   tb_replay_checker u_chk (.*);

   // generous limit: 1363 requests plus response stalls, many times over
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 600000) begin
         $display("timeout");
         $display("== FAIL ==");
         $finish;
      end
   end

   // response side: random stall bursts, none in the quiet phase
   initial begin
      int n;
      @(negedge clock);
      rsp_tready <= 1'b1;
      forever begin
         n = $urandom_range(1, 40);
         repeat (n) @(negedge clock);
         if (!quiet_phase && $urandom_range(0, 1)) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // one request transaction, with an optional idle burst before it;
   // valid stays high after acceptance until the next one or an explicit stop
   task automatic send_request(logic [1:0] op, logic [255:0] key,
                               logic signed [63:0] expiry, logic signed [63:0] now);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_tdata <= {6'd0, now, expiry, key, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [255:0] random_key();
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic signed [63:0] random_time();
      return {$urandom, $urandom};
   endfunction

   initial begin
      logic signed [63:0] now, expiry;
      logic [1:0]         op;
      logic [255:0]       key;
      logic signed [63:0] t_min, t_max;
      t_min = {1'b1, 63'd0};
      t_max = {1'b0, {63{1'b1}}};
      for (int i = 0; i < 8; i++) key_pool[i] = random_key();
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes of keys and times, every operation, every status
      send_request(rkt_pkg::OP_GET, key_pool[0], 64'sd0, t_min);            // absent
      send_request(rkt_pkg::OP_RESERVE, key_pool[0], t_min, t_min);         // error, equal
      send_request(rkt_pkg::OP_RESERVE, key_pool[0], -64'sd5, 64'sd5);      // error, before
      send_request(rkt_pkg::OP_RESERVE, key_pool[0], t_max, t_min);         // ok
      send_request(rkt_pkg::OP_RESERVE, key_pool[0], t_max, t_min);         // exists
      send_request(rkt_pkg::OP_RESERVE, key_pool[1], 64'sd100, t_min);      // ok
      send_request(rkt_pkg::OP_GET, key_pool[1], 64'sd0, 64'sd0);
      send_request(rkt_pkg::OP_CONSUME, key_pool[1], 64'sd0, 64'sd0);
      send_request(rkt_pkg::OP_GET, key_pool[1], 64'sd0, 64'sd0);
      send_request(rkt_pkg::OP_RELEASE, key_pool[1], 64'sd0, 64'sd0);
      send_request(rkt_pkg::OP_GET, key_pool[1], t_max, 64'sd0);
      send_request(rkt_pkg::OP_CONSUME, key_pool[2], 64'sd0, 64'sd0);       // not found
      send_request(rkt_pkg::OP_RELEASE, key_pool[2], 64'sd0, 64'sd0);       // not found
      send_request(rkt_pkg::OP_GET, key_pool[1], 64'sd0, 64'sd100);         // expired at equal
      // fill the table, then the last two give full
      for (int i = 0; i < rkt_pkg::ENTRIES + 1; i++) begin
         key = random_key();
         if (i == 3) key = key_pool[3];
         send_request(rkt_pkg::OP_RESERVE, key, t_max, 64'sd0);
      end
      // the table is full; wait it out before continuing
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      send_request(rkt_pkg::OP_GET, key_pool[3], 64'sd0, t_max);     // purges every entry
      send_request(rkt_pkg::OP_RESERVE, key_pool[4], t_max, t_max - 1);

      // random: clock advances slowly so entries live for a while, then expire
      now = 64'sd0;
      for (int n = 0; n < 1330; n++) begin
         if (n == 1200) quiet_phase = 1'b1;
         if (n == 600) begin
            req_tvalid <= 1'b0;
            while (pending_count != 0) @(negedge clock);
         end
         case ($urandom_range(0, 9))
            0: now = random_time();
            1, 2: now = now + 64'($urandom_range(1, 40));
            default: ;
         endcase
         op = 2'($urandom_range(0, 3));
         key = ($urandom_range(0, 9) == 0) ? random_key() : key_pool[$urandom_range(0, 7)];
         case ($urandom_range(0, 7))
            0: expiry = random_time();
            1: expiry = now - 64'($urandom_range(0, 3));
            2: expiry = t_max;
            default: expiry = now + 64'($urandom_range(1, 200));
         endcase
         if (op == rkt_pkg::OP_RESERVE && $urandom_range(0, 1))
            key = random_key();                                    // fill toward full
         send_request(op, key, expiry, now);
      end

      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

### sim.f
+incdir+hdl
hdl/rkt_pkg.sv
hdl/rkt_front.sv
hdl/rkt_back.sv
hdl/replay_key_table_with_expiry_top.sv
hdl/rkt_checker.sv
bench/tb_replay_checker.sv
bench/tb.sv
